[sv/chained_hash_map_engine_macros.svh]
// assertion macros shared by the hash map engine modules
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH

// condition holds in the same cycle
`define CHM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define CHM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/chm_pkg.sv]
// types, constants and hash function of the chained hash map engine
`timescale 1ns / 1ps
package chm_pkg;

	localparam int BUCKETS_DEF  = 64;
	localparam int CAPACITY_DEF = 128;
	localparam int HASH_MUL     = 13;
	localparam int HASH_SHIFT   = 15;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        found;
		logic        full_res;
		logic [7:0]  entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_PUT = 3'd0,
		OP_GET = 3'd1,
		OP_REM = 3'd2,
		OP_POP = 3'd3,
		OP_CLR = 3'd4,
		OP_NOP = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] value;
		logic [31:0] hash;
	} entry_t;

	function automatic logic [31:0] key_hash(input logic [31:0] k);
		logic [31:0] prod;
		prod = 32'(k * 32'(HASH_MUL));
		return prod ^ (k >> HASH_SHIFT);
	endfunction

endpackage

[sv/chained_hash_map_engine.sv]
// top level of the chained hash map engine
`timescale 1ns / 1ps
// chained hash map engine: key-value store with chained buckets in a node pool
// request channel: req is taken at a rising edge where start is high and busy low;
//   func selects put, get, remove, pop or empty all (other codes do nothing)
// result channel: done is high for exactly one cycle with rsp valid; the
//   receiver must take it then, there is no way to hold results off
// a front end classifies and hashes each request into a two-entry queue,
//   so requests are taken while the back end is still working; busy is
//   high only while the queue is full
// back end, from queue head to done: empty all and unknown codes finish
//   straight from idle; get, put and remove read the bucket head, then
//   check and compare each chain node over the single node memory read
//   port; a put of a new key then searches the pool eight nodes at a time
//   for a free node; pop scans buckets upward from zero to the first
//   non-empty one. the back end takes a new request only once idle again
// reset: all buckets empty, pool free, count zero; no clearing pass is
//   needed as bucket and node occupancy live in flip-flops
module chained_hash_map_engine #(
	parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
	parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  chm_pkg::req_t req,
	output logic          done,
	output chm_pkg::rsp_t rsp
);
	import chm_pkg::*;

	// classified request on its way into the queue
	entry_t f_ent;
	// queue head seen by the back end
	entry_t q_ent;
	logic   q_full;
	logic   q_nempty;
	logic   q_pop;
	logic   push;

	// request accepted whenever the queue has a free slot
	assign push = start && !q_full;
	assign busy = q_full;

	chm_front u_front (
		.req (req),
		.ent (f_ent)
	);

	chm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_ent),
		.pop    (q_pop),
		.rdata  (q_ent),
		.full   (q_full),
		.nempty (q_nempty)
	);

	// chain walker with bucket head and node memories
	chm_back #(
		.BUCKETS  (BUCKETS),
		.CAPACITY (CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_ent    (q_ent),
		.q_nempty (q_nempty),
		.q_pop    (q_pop),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

[sv/chm_front.sv]
// front end: classifies the operation code and hashes the key
`timescale 1ns / 1ps
module chm_front (
	input  chm_pkg::req_t   req,
	output chm_pkg::entry_t ent
);
	import chm_pkg::*;

	op_t op;

	always_comb begin
		unique case (req.func)
			OP_PUT:  op = OP_PUT;
			OP_GET:  op = OP_GET;
			OP_REM:  op = OP_REM;
			OP_POP:  op = OP_POP;
			OP_CLR:  op = OP_CLR;
			default: op = OP_NOP;
		endcase
	end

	assign ent.op    = op;
	assign ent.key   = req.key;
	assign ent.value = req.value;
	assign ent.hash  = key_hash(req.key);

endmodule

[sv/chm_fifo.sv]
// two-entry request queue between front and back
`timescale 1ns / 1ps
module chm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  chm_pkg::entry_t wdata,
	input  logic            pop,
	output chm_pkg::entry_t rdata,
	output logic            full,
	output logic            nempty
);
	import chm_pkg::*;
	`include "chained_hash_map_engine_macros.svh"

	entry_t     ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] lvl_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			lvl_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			lvl_q <= lvl_q + 2'(push) - 2'(pop);
		end
	end

	assign rdata  = ent_q[rp_q];
	assign full   = (lvl_q == 2'd2);
	assign nempty = (lvl_q != 2'd0);

	`CHM_ASSERT_IMP(a_no_overflow, push, !full || pop, "request queue overflow")
	`CHM_ASSERT_IMP(a_no_underflow, pop, nempty, "request queue underflow")
	`CHM_ASSERT_IMP(a_level, 1'b1, lvl_q <= 2'd2, "request queue level out of range")

endmodule

[sv/chm_back.sv]
// back end: walks bucket chains in memory and carries out each request
`timescale 1ns / 1ps
module chm_back #(
	parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
	parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  chm_pkg::entry_t q_ent,
	input  logic            q_nempty,
	output logic            q_pop,
	output logic            done,
	output chm_pkg::rsp_t   rsp
);
	import chm_pkg::*;
	`include "chained_hash_map_engine_macros.svh"

	localparam int BKT_W = $clog2(BUCKETS);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int PTR_W = $clog2(CAPACITY + 1);
	localparam int CNT_W = PTR_W;
	localparam int NGRP  = (CAPACITY + 7) / 8;
	localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_HEAD, S_CHK, S_CMP, S_FREE, S_PSCAN, S_PHEAD, S_PNODE
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [31:0]         key_q;
	logic [31:0]         val_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [PTR_W-1:0]    cur_q;
	logic [IDX_W-1:0]    link_q;
	logic                link_head_q;
	logic [GRP_W-1:0]    grp_q;
	logic [BUCKETS-1:0]  ne_q;
	logic [CAPACITY-1:0] used_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [31:0]         res_val_q;
	logic                res_found_q;
	logic                res_full_q;

	logic [PTR_W-1:0] head_mem [BUCKETS];
	logic [PTR_W-1:0] next_mem [CAPACITY];
	logic [31:0]      key_mem  [CAPACITY];
	logic [31:0]      val_mem  [CAPACITY];
	logic [PTR_W-1:0] head_rd_q;
	logic [PTR_W-1:0] next_rd_q;
	logic [31:0]      key_rd_q;
	logic [31:0]      val_rd_q;

	logic [BKT_W-1:0]  hd_ra;
	logic [IDX_W-1:0]  nd_ra;
	logic [IDX_W-1:0]  cur_idx;
	logic              link_we;
	logic [PTR_W-1:0]  link_wd;
	logic              node_we;
	logic              valw_we;
	logic [IDX_W-1:0]  node_wa;
	logic [NGRP*8-1:0] used_pad;
	logic [7:0]        grp_bits;
	logic              free_hit;
	logic [2:0]        free_pos;
	logic [IDX_W-1:0]  free_idx;
	logic              key_hit;

	assign cur_idx = IDX_W'(cur_q - PTR_W'(1));
	assign key_hit = (key_rd_q == key_q);

	// first free node in the current group of eight
	always_comb begin
		used_pad = '1;
		used_pad[CAPACITY-1:0] = used_q;
		grp_bits = used_pad[grp_q*8 +: 8];
		free_hit = 1'b0;
		free_pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!grp_bits[i]) begin
				free_hit = 1'b1;
				free_pos = 3'(i);
			end
		end
		free_idx = IDX_W'(int'(grp_q) * 8 + int'(free_pos));
	end

	// memory addresses and write strobes
	always_comb begin
		hd_ra   = (state_q == S_IDLE) ? q_ent.hash[BKT_W-1:0] : bkt_q;
		nd_ra   = (state_q == S_PHEAD) ? IDX_W'(head_rd_q - PTR_W'(1)) : cur_idx;
		link_we = 1'b0;
		link_wd = next_rd_q;
		node_we = 1'b0;
		valw_we = 1'b0;
		node_wa = cur_idx;
		case (state_q)
			S_CMP: begin
				if (key_hit && op_q == OP_REM) link_we = 1'b1;
				if (key_hit && op_q == OP_PUT) valw_we = 1'b1;
			end
			S_FREE: begin
				if (free_hit) begin
					link_we = 1'b1;
					link_wd = PTR_W'(free_idx) + PTR_W'(1);
					node_we = 1'b1;
					valw_we = 1'b1;
					node_wa = free_idx;
				end
			end
			S_PNODE: link_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[hd_ra];
		if (link_we && link_head_q) head_mem[bkt_q] <= link_wd;
	end

	always_ff @(posedge clk) begin
		next_rd_q <= next_mem[nd_ra];
		key_rd_q  <= key_mem[nd_ra];
		val_rd_q  <= val_mem[nd_ra];
		if (link_we && !link_head_q) next_mem[link_q] <= link_wd;
		if (node_we) begin
			next_mem[node_wa] <= '0;
			key_mem[node_wa]  <= key_q;
		end
		if (valw_we) val_mem[node_wa] <= val_q;
	end

	assign q_pop = (state_q == S_IDLE) && q_nempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NOP;
			key_q       <= '0;
			val_q       <= '0;
			bkt_q       <= '0;
			cur_q       <= '0;
			link_q      <= '0;
			link_head_q <= 1'b1;
			grp_q       <= '0;
			ne_q        <= '0;
			used_q      <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			res_val_q   <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (link_we && link_head_q) ne_q[bkt_q] <= (link_wd != '0);
			unique case (state_q)
				S_IDLE: begin
					if (q_nempty) begin
						op_q        <= q_ent.op;
						key_q       <= q_ent.key;
						val_q       <= q_ent.value;
						bkt_q       <= q_ent.hash[BKT_W-1:0];
						link_head_q <= 1'b1;
						res_val_q   <= '0;
						res_found_q <= 1'b0;
						res_full_q  <= 1'b0;
						unique case (q_ent.op)
							OP_PUT, OP_GET, OP_REM: state_q <= S_HEAD;
							OP_POP: begin
								bkt_q   <= '0;
								state_q <= S_PSCAN;
							end
							OP_CLR: begin
								ne_q   <= '0;
								used_q <= '0;
								cnt_q  <= '0;
								done_q <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_HEAD: begin
					cur_q   <= ne_q[bkt_q] ? head_rd_q : '0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cur_q == '0) begin
						if (op_q == OP_PUT && cnt_q != CNT_W'(CAPACITY)) begin
							grp_q   <= '0;
							state_q <= S_FREE;
						end else begin
							res_full_q <= (op_q == OP_PUT);
							done_q     <= 1'b1;
							state_q    <= S_IDLE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_hit) begin
						res_val_q   <= val_rd_q;
						res_found_q <= 1'b1;
						if (op_q == OP_REM) begin
							used_q[cur_idx] <= 1'b0;
							cnt_q           <= cnt_q - CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						link_q      <= cur_idx;
						link_head_q <= 1'b0;
						cur_q       <= next_rd_q;
						state_q     <= S_CHK;
					end
				end
				S_FREE: begin
					if (free_hit) begin
						used_q[free_idx] <= 1'b1;
						cnt_q            <= cnt_q + CNT_W'(1);
						done_q           <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				S_PSCAN: begin
					if (ne_q[bkt_q]) begin
						state_q <= S_PHEAD;
					end else if (bkt_q == BKT_W'(BUCKETS - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						bkt_q <= bkt_q + BKT_W'(1);
					end
				end
				S_PHEAD: begin
					cur_q   <= head_rd_q;
					state_q <= S_PNODE;
				end
				S_PNODE: begin
					res_val_q       <= val_rd_q;
					res_found_q     <= 1'b1;
					used_q[cur_idx] <= 1'b0;
					cnt_q           <= cnt_q - CNT_W'(1);
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done             = done_q;
	assign rsp.result_value = res_val_q;
	assign rsp.found        = res_found_q;
	assign rsp.full_res     = res_full_q;
	assign rsp.entry_count  = 8'(cnt_q);

	`CHM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "entry count beyond capacity")
	`CHM_ASSERT_IMP(a_found_full, done_q, !(res_found_q && res_full_q), "found and full together")
	`CHM_ASSERT_IMP(a_full_cnt, done_q && res_full_q, cnt_q == CNT_W'(CAPACITY),
		"put refused while pool has room")
	`CHM_ASSERT_NXT(a_alloc_room, state_q == S_FREE && free_hit, cnt_q != '0,
		"allocation left count at zero")

endmodule

[tb/chained_hash_map_engine_checker.sv]
// checker for the chained hash map engine: predicts every result and compares
`timescale 1ns / 1ps
module chained_hash_map_engine_checker #(
	parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
	parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  chm_pkg::req_t req,
	input  logic          done,
	input  chm_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	import chm_pkg::*;

	// map shadow, node i held as i+1 and 0 as null
	int          heads[BUCKETS];
	int          nxt[CAPACITY];
	logic [31:0] nkey[CAPACITY];
	logic [31:0] nval[CAPACITY];
	bit          used[CAPACITY];
	int          count;
	rsp_t        rsp_queue[$];

	function automatic int bucket_of(logic [31:0] k);
		logic [31:0] h;
		h = (k * 32'd13) ^ (k >> 15);
		return int'(h & 32'(BUCKETS - 1));
	endfunction

	function automatic void drop_node(int n);
		used[n] = 0;
		nxt[n] = 0;
		if (count > 0) count--;
	endfunction

	function automatic rsp_t map_apply(req_t r);
		rsp_t o;
		int   b, prev, p, i;
		o = '0;
		case (r.func)
			OP_PUT, OP_GET, OP_REM: begin
				b = bucket_of(r.key);
				prev = 0;
				p = heads[b];
				for (i = 0; i < CAPACITY && p != 0 && nkey[p-1] != r.key; i++) begin
					prev = p;
					p = nxt[p-1];
				end
				if (p != 0 && nkey[p-1] == r.key) begin
					o.result_value = nval[p-1];
					o.found = 1;
					if (r.func == OP_PUT) nval[p-1] = r.value;
					else if (r.func == OP_REM) begin
						if (prev == 0) heads[b] = nxt[p-1];
						else nxt[prev-1] = nxt[p-1];
						drop_node(p - 1);
					end
				end else if (r.func == OP_PUT) begin
					for (i = 0; i < CAPACITY && used[i]; i++) ;
					if (count >= CAPACITY || i >= CAPACITY) o.full_res = 1;
					else begin
						used[i] = 1;
						nkey[i] = r.key;
						nval[i] = r.value;
						nxt[i] = 0;
						if (prev == 0) heads[b] = i + 1;
						else nxt[prev-1] = i + 1;
						count++;
					end
				end
			end
			OP_POP: begin
				for (i = 0; i < BUCKETS; i++)
					if (heads[i] != 0) begin
						p = heads[i];
						o.result_value = nval[p-1];
						o.found = 1;
						heads[i] = nxt[p-1];
						drop_node(p - 1);
						break;
					end
			end
			OP_CLR: begin
				foreach (heads[j]) heads[j] = 0;
				foreach (used[j]) begin
					used[j] = 0;
					nxt[j] = 0;
				end
				count = 0;
			end
			default: ;
		endcase
		o.entry_count = 8'(count);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (heads[j]) heads[j] = 0;
			foreach (used[j]) begin
				used[j] = 0;
				nxt[j] = 0;
				nkey[j] = '0;
				nval[j] = '0;
			end
			count = 0;
			rsp_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result of an earlier request comes first when both happen at once
			if (done) begin
				if (rsp_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %p", rsp);
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.result_value !== want.result_value || rsp.found !== want.found ||
					    rsp.full_res !== want.full_res || rsp.entry_count !== want.entry_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", want, rsp);
					end
				end
			end
			if (start && !busy) rsp_queue.push_back(map_apply(req));
			pending = rsp_queue.size();
		end
	end
endmodule

[tb/chained_hash_map_engine_test.sv]
// testbench top of the chained hash map engine: stimulus and verdict
`timescale 1ns / 1ps
module chained_hash_map_engine_test;
	import chm_pkg::*;

	logic  clk = 0;
	logic  arst_n = 0;
	logic  start = 0;
	logic  busy, done;
	req_t  req = '0;
	rsp_t  rsp;
	int    fail_count, pending;
	logic [31:0] key_pool[16];

	always #5 clk = ~clk;

	chained_hash_map_engine u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	chained_hash_map_engine_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	// present one request and hold it until taken
	task automatic issue(logic [2:0] f, logic [31:0] k, logic [31:0] v);
		@(posedge clk);
		start <= 1;
		req <= '{func: f, key: k, value: v};
		do @(posedge clk); while (busy);
		start <= 0;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key(bit wide);
		if (wide || $urandom_range(0, 7) == 0) return $urandom();
		return key_pool[$urandom_range(0, 15)];
	endfunction

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int r, f;
		bit wide;
		foreach (key_pool[i]) key_pool[i] = (i < 8) ? i * 64 : $urandom();
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, every operation, empty pops, unknown codes
		issue(OP_POP, 0, 0);
		issue(OP_GET, 32'hFFFF_FFFF, 0);
		issue(OP_PUT, 0, 32'hFFFF_FFFF);
		issue(OP_PUT, 32'hFFFF_FFFF, 0);
		issue(OP_PUT, 0, 32'h1234_5678);
		issue(OP_PUT, 64, 1);
		issue(OP_PUT, 128, 2);
		issue(OP_GET, 64, 0);
		issue(OP_REM, 64, 0);
		issue(OP_REM, 64, 0);
		issue(OP_GET, 128, 0);
		issue(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(3'd6, 0, 0);
		issue(3'd7, 0, 0);
		issue(OP_POP, 0, 0);
		issue(OP_CLR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_GET, 0, 0);
		// fill the pool past capacity so the last puts are refused, then update key 0
		for (int i = 0; i < 132; i++) issue(OP_PUT, i * 7919, $urandom());
		issue(OP_PUT, 0, 5);
		drain();
		for (int i = 0; i < 130; i++) issue(OP_POP, 0, 0);
		// wait for every outstanding result before going on
		drain();

		for (int n = 0; n < 1520; n++) begin
			r = $urandom_range(0, 99);
			wide = ($urandom_range(0, 3) == 0);
			if (r < 40) f = OP_PUT;
			else if (r < 65) f = OP_GET;
			else if (r < 85) f = OP_REM;
			else if (r < 95) f = OP_POP;
			else if (r < 97) f = OP_CLR;
			else f = $urandom_range(5, 7);
			// refresh the key pool now and then for fresh chains
			if ($urandom_range(0, 99) == 0) key_pool[$urandom_range(0, 15)] = $urandom();
			issue(f[2:0], pick_key(wide), $urandom());
			idle_gap();
			if (n == 760) drain();
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
